// ----- design/cts_pkg.sv -----
// Package for the C-minus token scanner: token codes, scan modes, character
// constants, the keyword table and the result record shared by the modules.
// No dependencies.
`default_nettype none

package cts_pkg;

    // Default keyword buffer depth in characters.
    localparam int KEYWORD_MAX_CHARS_DEF = 6;

    // Keyword table geometry: eight keywords, each at most six characters.
    localparam int KW_COUNT  = 8;
    localparam int KW_TEXT_W = 48;

    // Result queue depth; a power of two so the pointers wrap on their own.
    localparam int RES_DEPTH = 4;

    // Token codes.
    localparam logic [4:0] TOK_ERR    = 5'd0;
    localparam logic [4:0] TOK_LPAREN = 5'd1;
    localparam logic [4:0] TOK_LBRACE = 5'd2;
    localparam logic [4:0] TOK_RPAREN = 5'd3;
    localparam logic [4:0] TOK_RBRACE = 5'd4;
    localparam logic [4:0] TOK_COMMA  = 5'd5;
    localparam logic [4:0] TOK_MINUS  = 5'd6;
    localparam logic [4:0] TOK_PLUS   = 5'd7;
    localparam logic [4:0] TOK_SEMI   = 5'd8;
    localparam logic [4:0] TOK_STAR   = 5'd9;
    localparam logic [4:0] TOK_SLASH  = 5'd10;
    localparam logic [4:0] TOK_NE     = 5'd11;
    localparam logic [4:0] TOK_EQEQ   = 5'd12;
    localparam logic [4:0] TOK_EQ     = 5'd13;
    localparam logic [4:0] TOK_LE     = 5'd14;
    localparam logic [4:0] TOK_LT     = 5'd15;
    localparam logic [4:0] TOK_GE     = 5'd16;
    localparam logic [4:0] TOK_GT     = 5'd17;
    localparam logic [4:0] TOK_INT    = 5'd18;
    localparam logic [4:0] TOK_VAR    = 5'd19;
    localparam logic [4:0] TOK_FUNC   = 5'd20;
    localparam logic [4:0] TOK_KW0    = 5'd21;
    localparam logic [4:0] TOK_END    = 5'd29;

    // Character codes the scanner looks at.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword spellings, first character in the lowest byte, zero padded.
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0000_6669,   // if
        48'h0000_6573_6C65,   // else
        48'h6E72_7574_6572,   // return
        48'h0065_6C69_6877,   // while
        48'h0000_0074_6E69,   // int
        48'h0000_6469_6F76,   // void
        48'h0074_7570_6E69,   // input
        48'h7475_7074_756F    // output
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd5, 4'd6
    };

    // Scanner state between characters.
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_IDSP,
        MODE_NUM,
        MODE_BANG,
        MODE_EQ,
        MODE_LT,
        MODE_GT,
        MODE_SLASH,
        MODE_COMMENT
    } mode_t;

    // One result token as it waits for the output side.
    typedef struct packed {
        logic [4:0]  token_code;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic [23:0] line_number;
        logic [15:0] column_number;
        logic        error_seen;
        logic        last;
    } res_t;

    // Up to two results written into the queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic is_ident_char(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Single-character punctuation code, or TOK_ERR when c is not one.
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        logic [4:0] p;
        case (c)
            CH_LPAREN: p = TOK_LPAREN;
            CH_LBRACE: p = TOK_LBRACE;
            CH_RPAREN: p = TOK_RPAREN;
            CH_RBRACE: p = TOK_RBRACE;
            CH_COMMA:  p = TOK_COMMA;
            CH_MINUS:  p = TOK_MINUS;
            CH_PLUS:   p = TOK_PLUS;
            CH_SEMI:   p = TOK_SEMI;
            CH_STAR:   p = TOK_STAR;
            default:   p = TOK_ERR;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- design/cts_result_fifo.sv -----
// Small result queue for the token scanner: takes up to two tokens per cycle
// and hands out one per transfer. Depends on cts_pkg.
`default_nettype none

module cts_result_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cts_pkg::push_t push,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cts_pkg::res_t       out_data
);

    localparam int DEPTH = cts_pkg::RES_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cts_pkg::res_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // Room means a full item's worth of results (two) still fits.
    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/cminus_token_scanner_unit.sv -----
// A token is written to the result queue on the edge that accepts the
// character completing it and is offered on m_axis from the head of that queue.
// Throughput: one character per cycle; a character that completes two tokens
// needs two output transfers, and input stalls only when the four-entry
// result queue has fewer than two free slots.
// Reset (rst_n, asynchronous, active low): idle between tokens, position 0,
// line 1, column 1, error flag clear, result queue empty.
//
// Top level of the C-minus token scanner; depends on cts_pkg and
// cts_result_fifo.
`default_nettype none

module cminus_token_scanner_unit #(
    parameter int KEYWORD_MAX_CHARS = cts_pkg::KEYWORD_MAX_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Source side: one character or end mark per transfer.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] kind (1 = end of source)

    // Token side: one token per transfer.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [31:0] start_offset, [47:32] token_length,
                                             // [71:48] line_number, [87:72] column_number,
                                             // [88] error_seen, [95:89] zero
    output logic [4:0]       m_axis_tuser,   // [4:0] token_code
    output logic             m_axis_tlast    // last token caused by its input item
);

    localparam int KW_W = KEYWORD_MAX_CHARS * 8;

    // The scanner state proper. The pending token is the one still being
    // collected; its fields are what it is reported with when it closes.
    cts_pkg::mode_t mode_reg, mode_next;
    logic [31:0]    pend_start_reg, pend_start_next;
    logic [15:0]    pend_len_reg, pend_len_next;
    logic [23:0]    pend_line_reg, pend_line_next;
    logic [15:0]    pend_col_reg, pend_col_next;
    logic [KW_W-1:0] kw_buf_reg, kw_buf_next;
    logic [31:0]    pos_reg, pos_next;
    logic [23:0]    line_reg, line_next;
    logic [15:0]    col_reg, col_next;
    logic           err_reg, err_next;

    logic           in_fire;
    logic           in_kind;
    logic [7:0]     ch;
    logic [4:0]     kw_code;
    logic [15:0]    len_grown;

    // Closing of the pending token by the incoming character.
    logic           res_emit;
    logic [4:0]     res_code;
    logic           res_consumed;
    logic           res_grow;
    logic           res_buf_wr;
    cts_pkg::mode_t mode_res;

    // Handling of a character that the pending token did not take.
    logic           st_emit;
    logic [4:0]     st_code;
    logic           st_begin;
    cts_pkg::mode_t st_mode;
    logic           st_error;

    cts_pkg::push_t push;
    cts_pkg::res_t  res_a, res_b, head;
    logic           room;

    assign in_kind       = s_axis_tuser;
    assign ch            = s_axis_tdata;
    assign s_axis_tready = room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign len_grown = (pend_len_reg == 16'hFFFF) ? pend_len_reg : pend_len_reg + 16'd1;

    // Keyword lookup. Unwritten buffer bytes stay zero, so a zero padded
    // compare plus an exact length match identifies the keyword; identifiers
    // longer than any keyword can never match on length.
    always_comb
    begin
        kw_code = cts_pkg::TOK_ERR;
        for (int k = 0; k < cts_pkg::KW_COUNT; k++)
        begin
            if (pend_len_reg == 16'(cts_pkg::KW_LEN[k])
                && kw_buf_reg == KW_W'(cts_pkg::KW_TEXT[k]))
            begin
                kw_code = cts_pkg::TOK_KW0 + 5'(k);
            end
        end
    end

    // Resolve the pending token against the incoming character or end mark.
    always_comb
    begin
        res_emit     = 1'b0;
        res_code     = cts_pkg::TOK_ERR;
        res_consumed = 1'b0;
        res_grow     = 1'b0;
        res_buf_wr   = 1'b0;
        mode_res     = cts_pkg::MODE_IDLE;
        if (in_kind)
        begin
            // End mark flushes whatever is open; a lone bang or comment ends quietly.
            case (mode_reg)
                cts_pkg::MODE_IDENT:
                begin
                    res_emit = 1'b1;
                    res_code = (kw_code != cts_pkg::TOK_ERR) ? kw_code : cts_pkg::TOK_VAR;
                end
                cts_pkg::MODE_IDSP:  begin res_emit = 1'b1; res_code = cts_pkg::TOK_VAR;   end
                cts_pkg::MODE_NUM:   begin res_emit = 1'b1; res_code = cts_pkg::TOK_INT;   end
                cts_pkg::MODE_EQ:    begin res_emit = 1'b1; res_code = cts_pkg::TOK_EQ;    end
                cts_pkg::MODE_LT:    begin res_emit = 1'b1; res_code = cts_pkg::TOK_LT;    end
                cts_pkg::MODE_GT:    begin res_emit = 1'b1; res_code = cts_pkg::TOK_GT;    end
                cts_pkg::MODE_SLASH: begin res_emit = 1'b1; res_code = cts_pkg::TOK_SLASH; end
                default:             res_emit = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                cts_pkg::MODE_IDENT:
                begin
                    if (cts_pkg::is_ident_char(ch))
                    begin
                        res_consumed = 1'b1;
                        res_grow     = 1'b1;
                        res_buf_wr   = 1'b1;
                        mode_res     = cts_pkg::MODE_IDENT;
                    end
                    else if (kw_code != cts_pkg::TOK_ERR)
                    begin
                        res_emit = 1'b1;
                        res_code = kw_code;
                    end
                    else if (ch == cts_pkg::CH_SPACE)
                    begin
                        // Spaces may still separate a function name from '('.
                        res_consumed = 1'b1;
                        mode_res     = cts_pkg::MODE_IDSP;
                    end
                    else
                    begin
                        res_emit = 1'b1;
                        res_code = (ch == cts_pkg::CH_LPAREN) ? cts_pkg::TOK_FUNC
                                                              : cts_pkg::TOK_VAR;
                    end
                end
                cts_pkg::MODE_IDSP:
                begin
                    if (ch == cts_pkg::CH_SPACE)
                    begin
                        res_consumed = 1'b1;
                        mode_res     = cts_pkg::MODE_IDSP;
                    end
                    else
                    begin
                        res_emit = 1'b1;
                        res_code = (ch == cts_pkg::CH_LPAREN) ? cts_pkg::TOK_FUNC
                                                              : cts_pkg::TOK_VAR;
                    end
                end
                cts_pkg::MODE_NUM:
                begin
                    if (cts_pkg::is_digit(ch))
                    begin
                        res_consumed = 1'b1;
                        res_grow     = 1'b1;
                        mode_res     = cts_pkg::MODE_NUM;
                    end
                    else
                    begin
                        res_emit = 1'b1;
                        res_code = cts_pkg::TOK_INT;
                    end
                end
                cts_pkg::MODE_BANG:
                begin
                    // A bang without '=' is dropped and the character rescanned.
                    if (ch == cts_pkg::CH_EQUAL)
                    begin
                        res_consumed = 1'b1;
                        res_grow     = 1'b1;
                        res_emit     = 1'b1;
                        res_code     = cts_pkg::TOK_NE;
                    end
                end
                cts_pkg::MODE_EQ, cts_pkg::MODE_LT, cts_pkg::MODE_GT:
                begin
                    res_emit = 1'b1;
                    if (ch == cts_pkg::CH_EQUAL)
                    begin
                        res_consumed = 1'b1;
                        res_grow     = 1'b1;
                        res_code     = (mode_reg == cts_pkg::MODE_EQ) ? cts_pkg::TOK_EQEQ :
                                       (mode_reg == cts_pkg::MODE_LT) ? cts_pkg::TOK_LE
                                                                      : cts_pkg::TOK_GE;
                    end
                    else
                    begin
                        res_code     = (mode_reg == cts_pkg::MODE_EQ) ? cts_pkg::TOK_EQ :
                                       (mode_reg == cts_pkg::MODE_LT) ? cts_pkg::TOK_LT
                                                                      : cts_pkg::TOK_GT;
                    end
                end
                cts_pkg::MODE_SLASH:
                begin
                    if (ch == cts_pkg::CH_SLASH)
                    begin
                        res_consumed = 1'b1;
                        mode_res     = cts_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        res_emit = 1'b1;
                        res_code = cts_pkg::TOK_SLASH;
                    end
                end
                cts_pkg::MODE_COMMENT:
                begin
                    // The newline ends the comment and is then scanned as whitespace.
                    if (ch != cts_pkg::CH_NL)
                    begin
                        res_consumed = 1'b1;
                        mode_res     = cts_pkg::MODE_COMMENT;
                    end
                end
                default:
                begin
                    res_consumed = 1'b0;
                end
            endcase
        end
    end

    // Start of a new token, or the end marker after an end mark.
    always_comb
    begin
        st_emit  = 1'b0;
        st_code  = cts_pkg::TOK_ERR;
        st_begin = 1'b0;
        st_mode  = cts_pkg::MODE_IDLE;
        st_error = 1'b0;
        if (in_kind)
        begin
            st_emit = 1'b1;
            st_code = cts_pkg::TOK_END;
        end
        else if (!res_consumed)
        begin
            if (cts_pkg::punct_code(ch) != cts_pkg::TOK_ERR)
            begin
                st_emit = 1'b1;
                st_code = cts_pkg::punct_code(ch);
            end
            else
            begin
                case (ch)
                    cts_pkg::CH_BANG:  begin st_begin = 1'b1; st_mode = cts_pkg::MODE_BANG;  end
                    cts_pkg::CH_EQUAL: begin st_begin = 1'b1; st_mode = cts_pkg::MODE_EQ;    end
                    cts_pkg::CH_LESS:  begin st_begin = 1'b1; st_mode = cts_pkg::MODE_LT;    end
                    cts_pkg::CH_GREAT: begin st_begin = 1'b1; st_mode = cts_pkg::MODE_GT;    end
                    cts_pkg::CH_SLASH: begin st_begin = 1'b1; st_mode = cts_pkg::MODE_SLASH; end
                    cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_CR, cts_pkg::CH_NL:
                    begin
                        st_begin = 1'b0;
                    end
                    default:
                    begin
                        if (cts_pkg::is_digit(ch))
                        begin
                            st_begin = 1'b1;
                            st_mode  = cts_pkg::MODE_NUM;
                        end
                        else if (cts_pkg::is_ident_char(ch))
                        begin
                            st_begin = 1'b1;
                            st_mode  = cts_pkg::MODE_IDENT;
                        end
                        else
                        begin
                            st_emit  = 1'b1;
                            st_error = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Next state of the scanner and the position counters.
    always_comb
    begin
        mode_next       = mode_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        pend_line_next  = pend_line_reg;
        pend_col_next   = pend_col_reg;
        kw_buf_next     = kw_buf_reg;
        pos_next        = pos_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        err_next        = err_reg;
        if (in_fire)
        begin
            mode_next = st_begin ? st_mode : mode_res;
            err_next  = err_reg | st_error;
            if (st_begin)
            begin
                pend_start_next = pos_reg;
                pend_len_next   = 16'd1;
                pend_line_next  = line_reg;
                pend_col_next   = col_reg;
            end
            else if (res_grow)
            begin
                pend_len_next = len_grown;
            end
            if (st_begin && st_mode == cts_pkg::MODE_IDENT)
            begin
                kw_buf_next = KW_W'(ch);
            end
            else if (res_buf_wr)
            begin
                // Only the first KEYWORD_MAX_CHARS characters are kept.
                for (int i = 0; i < KEYWORD_MAX_CHARS; i++)
                begin
                    if (pend_len_reg == 16'(i))
                    begin
                        kw_buf_next[i*8 +: 8] = ch;
                    end
                end
            end
            if (!in_kind)
            begin
                pos_next = pos_reg + 32'd1;
                if (ch == cts_pkg::CH_NL)
                begin
                    line_next = (line_reg == 24'hFFFFFF) ? line_reg : line_reg + 24'd1;
                    col_next  = 16'd1;
                end
                else
                begin
                    col_next = (col_reg == 16'hFFFF) ? col_reg : col_reg + 16'd1;
                end
            end
        end
    end

    // Result records. The pending token reports the error flag as it stood
    // before this character; a new token sees an error raised by itself.
    always_comb
    begin
        res_a.token_code    = res_code;
        res_a.start_offset  = pend_start_reg;
        res_a.token_length  = res_grow ? len_grown : pend_len_reg;
        res_a.line_number   = pend_line_reg;
        res_a.column_number = pend_col_reg;
        res_a.error_seen    = err_reg;
        res_a.last          = !st_emit;

        res_b.token_code    = st_code;
        res_b.start_offset  = pos_reg;
        res_b.token_length  = in_kind ? 16'd0 : 16'd1;
        res_b.line_number   = line_reg;
        res_b.column_number = col_reg;
        res_b.error_seen    = err_reg | st_error;
        res_b.last          = 1'b1;

        push.first  = res_emit ? res_a : res_b;
        push.second = res_b;
        push.count  = in_fire ? 2'({1'b0, res_emit} + {1'b0, st_emit}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= cts_pkg::MODE_IDLE;
            pend_start_reg <= '0;
            pend_len_reg   <= '0;
            pend_line_reg  <= 24'd1;
            pend_col_reg   <= 16'd1;
            kw_buf_reg     <= '0;
            pos_reg        <= '0;
            line_reg       <= 24'd1;
            col_reg        <= 16'd1;
            err_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            pend_line_reg  <= pend_line_next;
            pend_col_reg   <= pend_col_next;
            kw_buf_reg     <= kw_buf_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            err_reg        <= err_next;
        end
    end

    // The result queue decouples the token side, so characters keep flowing
    // while a finished token waits for its transfer.
    cts_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tuser = head.token_code;
    assign m_axis_tlast = head.last;
    assign m_axis_tdata = {7'd0, head.error_seen, head.column_number, head.line_number,
                           head.token_length, head.start_offset};

`ifndef SYNTHESIS
    // The end marker always closes the results of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == cts_pkg::TOK_END |-> m_axis_tlast)
        else $error("end marker without tlast");

    // An end mark leaves the scanner idle between tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_kind |=> mode_reg == cts_pkg::MODE_IDLE)
        else $error("scanner not idle after end mark");

    // A newline character restarts the column count.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_kind && ch == cts_pkg::CH_NL |=> col_reg == 16'd1)
        else $error("column not reset after newline");

    // The error flag is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag cleared");
`endif

endmodule

`default_nettype wire

// ----- bench/cminus_token_scanner_unit_checker.sv -----
`timescale 1ns / 100ps
// Token checker for the C-minus scanner bench: watches both stream channels,
// predicts the tokens each accepted character causes and compares them.
// Depends on cts_pkg for token codes, character codes and the result record.

module cminus_token_scanner_unit_checker #(
    parameter int KW_CHARS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          tokens_pending
);

    string kw_spell [8] = '{"if", "else", "return", "while", "int", "void", "input", "output"};

    // Scanner state as the predictor sees it.
    cts_pkg::mode_t mode;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    logic [23:0] tok_line;
    logic [15:0] tok_col;
    logic [7:0]  kw_buf [KW_CHARS];
    logic [31:0] pos;
    logic [23:0] line;
    logic [15:0] col;
    logic        err_flag;

    cts_pkg::res_t step_tokens [$];
    cts_pkg::res_t expected_tokens [$];

    initial
    begin
        mismatch_count = 0;
        tokens_pending = 0;
    end

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || c == 8'h5F;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic void push_token(input logic [4:0] code, input logic [31:0] start,
                                       input logic [15:0] len, input logic [23:0] ln,
                                       input logic [15:0] cl);
        cts_pkg::res_t t;
        if (step_tokens.size() >= 2)
            return;
        t.token_code    = code;
        t.start_offset  = start;
        t.token_length  = len;
        t.line_number   = ln;
        t.column_number = cl;
        t.error_seen    = err_flag;
        t.last          = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void add_held(input logic [4:0] code);
        push_token(code, tok_start, tok_len, tok_line, tok_col);
    endfunction

    function automatic void open_token(input cts_pkg::mode_t m);
        mode      = m;
        tok_start = pos;
        tok_len   = 16'd1;
        tok_line  = line;
        tok_col   = col;
    endfunction

    function automatic void grow_token();
        if (tok_len != 16'hFFFF)
            tok_len++;
    endfunction

    // Keyword code of the held identifier, TOK_ERR when it is not a keyword.
    function automatic logic [4:0] keyword_code();
        logic hit;
        if (tok_len > KW_CHARS)
            return cts_pkg::TOK_ERR;
        for (int k = 0; k < 8; k++)
        begin
            if (kw_spell[k].len() == tok_len)
            begin
                hit = 1'b1;
                for (int i = 0; i < kw_spell[k].len(); i++)
                    if (kw_spell[k][i] != kw_buf[i])
                        hit = 1'b0;
                if (hit)
                    return cts_pkg::TOK_KW0 + 5'(k);
            end
        end
        return cts_pkg::TOK_ERR;
    endfunction

    // Lets the held token take the character; returns 1 when it is used up.
    function automatic logic continue_token(input logic [7:0] c);
        logic [4:0] kw;
        case (mode)
            cts_pkg::MODE_IDENT:
            begin
                if (is_letter(c))
                begin
                    if (tok_len < KW_CHARS)
                        kw_buf[tok_len] = c;
                    grow_token();
                    return 1'b1;
                end
                kw = keyword_code();
                mode = cts_pkg::MODE_IDLE;
                if (kw != cts_pkg::TOK_ERR)
                begin
                    add_held(kw);
                    return 1'b0;
                end
                if (c == cts_pkg::CH_SPACE)
                begin
                    mode = cts_pkg::MODE_IDSP;
                    return 1'b1;
                end
                add_held(c == cts_pkg::CH_LPAREN ? cts_pkg::TOK_FUNC : cts_pkg::TOK_VAR);
                return 1'b0;
            end
            cts_pkg::MODE_IDSP:
            begin
                if (c == cts_pkg::CH_SPACE)
                    return 1'b1;
                add_held(c == cts_pkg::CH_LPAREN ? cts_pkg::TOK_FUNC : cts_pkg::TOK_VAR);
                mode = cts_pkg::MODE_IDLE;
                return 1'b0;
            end
            cts_pkg::MODE_NUM:
            begin
                if (is_numeral(c))
                begin
                    grow_token();
                    return 1'b1;
                end
                add_held(cts_pkg::TOK_INT);
                mode = cts_pkg::MODE_IDLE;
                return 1'b0;
            end
            cts_pkg::MODE_BANG:
            begin
                mode = cts_pkg::MODE_IDLE;
                if (c == cts_pkg::CH_EQUAL)
                begin
                    grow_token();
                    add_held(cts_pkg::TOK_NE);
                    return 1'b1;
                end
                return 1'b0;
            end
            cts_pkg::MODE_EQ, cts_pkg::MODE_LT, cts_pkg::MODE_GT:
            begin
                if (c == cts_pkg::CH_EQUAL)
                begin
                    grow_token();
                    add_held(mode == cts_pkg::MODE_EQ ? cts_pkg::TOK_EQEQ :
                             (mode == cts_pkg::MODE_LT ? cts_pkg::TOK_LE : cts_pkg::TOK_GE));
                    mode = cts_pkg::MODE_IDLE;
                    return 1'b1;
                end
                add_held(mode == cts_pkg::MODE_EQ ? cts_pkg::TOK_EQ :
                         (mode == cts_pkg::MODE_LT ? cts_pkg::TOK_LT : cts_pkg::TOK_GT));
                mode = cts_pkg::MODE_IDLE;
                return 1'b0;
            end
            cts_pkg::MODE_SLASH:
            begin
                if (c == cts_pkg::CH_SLASH)
                begin
                    mode = cts_pkg::MODE_COMMENT;
                    return 1'b1;
                end
                add_held(cts_pkg::TOK_SLASH);
                mode = cts_pkg::MODE_IDLE;
                return 1'b0;
            end
            cts_pkg::MODE_COMMENT:
            begin
                if (c == cts_pkg::CH_NL)
                begin
                    mode = cts_pkg::MODE_IDLE;
                    return 1'b0;
                end
                return 1'b1;
            end
            default:
            begin
                mode = cts_pkg::MODE_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void start_token(input logic [7:0] c);
        logic [4:0] p;
        p = cts_pkg::TOK_ERR;
        case (c)
            cts_pkg::CH_LPAREN: p = cts_pkg::TOK_LPAREN;
            cts_pkg::CH_LBRACE: p = cts_pkg::TOK_LBRACE;
            cts_pkg::CH_RPAREN: p = cts_pkg::TOK_RPAREN;
            cts_pkg::CH_RBRACE: p = cts_pkg::TOK_RBRACE;
            cts_pkg::CH_COMMA:  p = cts_pkg::TOK_COMMA;
            cts_pkg::CH_MINUS:  p = cts_pkg::TOK_MINUS;
            cts_pkg::CH_PLUS:   p = cts_pkg::TOK_PLUS;
            cts_pkg::CH_SEMI:   p = cts_pkg::TOK_SEMI;
            cts_pkg::CH_STAR:   p = cts_pkg::TOK_STAR;
            cts_pkg::CH_BANG:   begin open_token(cts_pkg::MODE_BANG);  return; end
            cts_pkg::CH_EQUAL:  begin open_token(cts_pkg::MODE_EQ);    return; end
            cts_pkg::CH_LESS:   begin open_token(cts_pkg::MODE_LT);    return; end
            cts_pkg::CH_GREAT:  begin open_token(cts_pkg::MODE_GT);    return; end
            cts_pkg::CH_SLASH:  begin open_token(cts_pkg::MODE_SLASH); return; end
            cts_pkg::CH_SPACE, cts_pkg::CH_TAB, cts_pkg::CH_CR, cts_pkg::CH_NL: return;
            default: ;
        endcase
        if (p != cts_pkg::TOK_ERR)
            push_token(p, pos, 16'd1, line, col);
        else if (is_numeral(c))
            open_token(cts_pkg::MODE_NUM);
        else if (is_letter(c))
        begin
            open_token(cts_pkg::MODE_IDENT);
            foreach (kw_buf[i])
                kw_buf[i] = 8'h00;
            kw_buf[0] = c;
        end
        else
        begin
            err_flag = 1'b1;
            push_token(cts_pkg::TOK_ERR, pos, 16'd1, line, col);
        end
    endfunction

    function automatic void commit_step();
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
        step_tokens.delete();
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (!continue_token(c))
            start_token(c);
        pos++;
        if (c == cts_pkg::CH_NL)
        begin
            if (line != 24'hFFFFFF)
                line++;
            col = 16'd1;
        end
        else if (col != 16'hFFFF)
            col++;
        commit_step();
    endfunction

    // End of source: the held token is flushed, then the end marker follows.
    function automatic void end_of_source();
        logic [4:0] kw;
        case (mode)
            cts_pkg::MODE_IDENT:
            begin
                kw = keyword_code();
                add_held(kw != cts_pkg::TOK_ERR ? kw : cts_pkg::TOK_VAR);
            end
            cts_pkg::MODE_IDSP:  add_held(cts_pkg::TOK_VAR);
            cts_pkg::MODE_NUM:   add_held(cts_pkg::TOK_INT);
            cts_pkg::MODE_EQ:    add_held(cts_pkg::TOK_EQ);
            cts_pkg::MODE_LT:    add_held(cts_pkg::TOK_LT);
            cts_pkg::MODE_GT:    add_held(cts_pkg::TOK_GT);
            cts_pkg::MODE_SLASH: add_held(cts_pkg::TOK_SLASH);
            default: ;
        endcase
        mode = cts_pkg::MODE_IDLE;
        push_token(cts_pkg::TOK_END, pos, 16'd0, line, col);
        commit_step();
    endfunction

    function automatic void reset_scanner();
        mode      = cts_pkg::MODE_IDLE;
        tok_start = '0;
        tok_len   = '0;
        tok_line  = 24'd1;
        tok_col   = 16'd1;
        foreach (kw_buf[i])
            kw_buf[i] = 8'h00;
        pos       = '0;
        line      = 24'd1;
        col       = 16'd1;
        err_flag  = 1'b0;
        step_tokens.delete();
        expected_tokens.delete();
    endfunction

    function automatic void check_token();
        cts_pkg::res_t want;
        logic good;
        if (expected_tokens.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: token code %0d at offset %0d arrived with none expected",
                         $realtime, m_tuser, m_tdata[31:0]);
            return;
        end
        want = expected_tokens.pop_front();
        good = m_tuser == want.token_code && m_tdata[31:0] == want.start_offset
            && m_tdata[47:32] == want.token_length && m_tdata[71:48] == want.line_number
            && m_tdata[87:72] == want.column_number && m_tdata[88] == want.error_seen
            && m_tdata[95:89] == 7'd0 && m_tlast == want.last;
        if (!good)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display({"%0t: token mismatch, expected code %0d off %0d len %0d",
                          " ln %0d col %0d err %0b last %0b"},
                         $realtime, want.token_code, want.start_offset, want.token_length,
                         want.line_number, want.column_number, want.error_seen, want.last);
                $display({"%0t:                   got code %0d off %0d len %0d",
                          " ln %0d col %0d err %0b last %0b pad %h"},
                         $realtime, m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[71:48],
                         m_tdata[87:72], m_tdata[88], m_tlast, m_tdata[95:89]);
            end
        end
    endfunction

    // Outputs are checked before the new character is predicted: a token can
    // never leave the block on the edge that accepts its last character.
    always @(posedge clk)
    begin
        if (!rst_n)
            reset_scanner();
        else
        begin
            if (m_tvalid && m_tready)
                check_token();
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                    end_of_source();
                else
                    scan_char(s_tdata);
            end
        end
        tokens_pending = expected_tokens.size();
    end

endmodule

// ----- bench/cminus_token_scanner_unit_tb.sv -----
`timescale 1ns / 100ps
// Top of the C-minus token scanner bench: clock, reset, character stimulus and
// the verdict. Depends on cts_pkg, cminus_token_scanner_unit and the checker.

module cminus_token_scanner_unit_tb;

    // Generous bound on the run, in clock cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Source items (characters and end marks) to send in total, directed part included.
    localparam int ITEM_GOAL   = 600;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] char_code
    logic        s_axis_tuser;    // [0] kind (1 = end of source)
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;    // [31:0] start_offset, [47:32] token_length,
                                  // [71:48] line_number, [87:72] column_number,
                                  // [88] error_seen, [95:89] zero
    logic [4:0]  m_axis_tuser;    // [4:0] token_code
    logic        m_axis_tlast;

    int mismatch_count;
    int tokens_pending;
    int cycle_count;
    int burst_left;
    int items_sent;
    int stall_kind;
    int stall_len;
    bit drained;

    string kw_list [8] = '{"if", "else", "return", "while", "int", "void", "input", "output"};
    string op_list [9] = '{"!=", "==", "=", "<=", "<", ">=", ">", "!", "/"};
    logic [7:0] punct_list [9] = '{cts_pkg::CH_LPAREN, cts_pkg::CH_LBRACE,
                                   cts_pkg::CH_RPAREN, cts_pkg::CH_RBRACE,
                                   cts_pkg::CH_COMMA, cts_pkg::CH_MINUS,
                                   cts_pkg::CH_PLUS, cts_pkg::CH_SEMI, cts_pkg::CH_STAR};

    cminus_token_scanner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker sees the same pins as the block and owns all prediction.
    cminus_token_scanner_unit_checker token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tuser        (s_axis_tuser),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .tokens_pending (tokens_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost token ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // The token side stalls in phases of its own: always ready, coin flip,
    // mostly stalled, or a short hard stall. This keeps the result queue
    // filling up at every point of a token's life.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            stall_kind = $urandom_range(0, 3);
            stall_len  = (stall_kind == 3) ? $urandom_range(1, 10) : $urandom_range(4, 40);
            repeat (stall_len)
            begin
                @(negedge clk);
                case (stall_kind)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = $urandom_range(0, 1);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = 1'b0;
                endcase
            end
        end
    end

    // One source transfer. The sender works in bursts; when a burst runs out
    // it drops valid for a random gap before the next one. Called and left at
    // a falling edge, so every input change happens away from the sampling edge.
    task automatic drive_item(input logic kind, input logic [7:0] code);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = code;
        s_axis_tuser  = kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            drive_item(1'b0, s[i]);
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'h61 + 8'(r);
        else if (r < 52)
            return 8'h41 + 8'(r - 26);
        return cts_pkg::CH_UNDER;
    endfunction

    // Stops sending and waits until every predicted token has been taken.
    task automatic wait_for_tokens();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (tokens_pending != 0)
            @(negedge clk);
    endtask

    // One random lexeme, mostly well formed so the scanner walks through all
    // of its modes, with some stray bytes and end marks mixed in. A separator
    // follows only sometimes, so tokens also butt against each other.
    task automatic send_random_token();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // Keyword, sometimes lengthened into a plain or overlong identifier.
            send_text(kw_list[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) drive_item(1'b0, random_letter());
        end
        else if (pick < 30)
            repeat ($urandom_range(1, 9)) drive_item(1'b0, random_letter());
        else if (pick < 38)
        begin
            // Call site: name, optional spaces, then an opening parenthesis.
            if ($urandom_range(0, 2) == 0)
                send_text(kw_list[$urandom_range(0, 7)]);
            else
                repeat ($urandom_range(1, 8)) drive_item(1'b0, random_letter());
            repeat ($urandom_range(0, 2)) drive_item(1'b0, cts_pkg::CH_SPACE);
            drive_item(1'b0, cts_pkg::CH_LPAREN);
        end
        else if (pick < 48)
            repeat ($urandom_range(1, 5))
                drive_item(1'b0, 8'(cts_pkg::CH_ZERO + $urandom_range(0, 9)));
        else if (pick < 61)
            drive_item(1'b0, punct_list[$urandom_range(0, 8)]);
        else if (pick < 73)
            send_text(op_list[$urandom_range(0, 8)]);
        else if (pick < 78)
        begin
            // Line comment with random printable text up to the newline.
            send_text("//");
            n = $urandom_range(0, 8);
            repeat (n) drive_item(1'b0, 8'($urandom_range(32, 126)));
            drive_item(1'b0, cts_pkg::CH_NL);
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 3))
                0:       drive_item(1'b0, cts_pkg::CH_SPACE);
                1:       drive_item(1'b0, cts_pkg::CH_TAB);
                2:       drive_item(1'b0, cts_pkg::CH_CR);
                default: drive_item(1'b0, cts_pkg::CH_NL);
            endcase
        end
        else if (pick < 95)
            drive_item(1'b0, 8'($urandom_range(0, 255)));
        else
            drive_item(1'b1, 8'($urandom_range(0, 255)));

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: drive_item(1'b0, cts_pkg::CH_SPACE);
            5:             drive_item(1'b0, cts_pkg::CH_NL);
            default: ;
        endcase
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        burst_left    = 0;
        items_sent    = 0;
        drained       = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part: a keyword, a call through a space, the <=, >= and ==
        // comparisons, a dropped bang, a lone slash, a line comment, the NUL and
        // all-ones bytes as errors, tab and carriage return as white space, and
        // an end mark that has to flush a pending identifier.
        send_text("int f (a)<=b>=c==d!x/y//z\n");
        drive_item(1'b0, 8'h00);
        drive_item(1'b0, 8'hFF);
        drive_item(1'b0, cts_pkg::CH_TAB);
        drive_item(1'b0, cts_pkg::CH_CR);
        drive_item(1'b0, 8'h77);
        drive_item(1'b1, 8'hA5);

        // Random part, with one full drain halfway through so the block is seen
        // restarting from an empty result queue.
        while (items_sent < ITEM_GOAL)
        begin
            if (!drained && items_sent >= ITEM_GOAL / 2)
            begin
                wait_for_tokens();
                drained = 1'b1;
            end
            send_random_token();
        end
        drive_item(1'b1, 8'($urandom_range(0, 255)));

        wait_for_tokens();
        repeat (12) @(negedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
